// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; clk_i and rst_ni are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cond never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_AT(lbl, !(cond), msg)

`endif

// ----- hw/rtl/sar_pkg.sv -----
`default_nettype none

package sar_pkg;

  localparam int unsigned DataBits = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned DivW     = 8;
  localparam int unsigned BitCntW  = 4;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SETUP = 3'd1,
    PH_CMD   = 3'd2,
    PH_NULL  = 3'd3,
    PH_MSB   = 3'd4,
    PH_LSB   = 3'd5
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_PERIOD  = 2'd0,
    CFG_SINGLE_ENDED = 2'd1,
    CFG_ODD_SELECT   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DivW-1:0] half_period;
    logic            single_ended;
    logic            odd_select;
  } cfg_t;

  typedef struct packed {
    logic                select_n;
    logic                serial_clock;
    logic                data_out;
    logic                drive_enable;
    logic                busy;
    logic                result_valid;
    logic [DataBits-1:0] msb_value;
    logic [DataBits-1:0] lsb_value;
    logic                agree;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/serial_adc_reader_top.sv -----
`default_nettype none

// Serial converter read master. Each input transaction is one tick of the pin
// sequencer (start request plus sampled data pin); each tick yields exactly one
// output transaction with the pin levels and the two assembled bytes. One
// transaction is taken per clock cycle; its result appears in the output
// register on the next cycle, and a new input is taken whenever that register
// is empty or is being drained in the same cycle. Configuration writes are
// always taken and apply to the following ticks.

module serial_adc_reader_top import sar_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                start_req_i,
  input  wire logic                data_in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     select_n_o,
  output logic                     serial_clock_o,
  output logic                     data_out_o,
  output logic                     drive_enable_o,
  output logic                     busy_res_o,
  output logic                     result_valid_o,
  output logic [DataBits-1:0]      msb_first_value_o,
  output logic [DataBits-1:0]      lsb_first_value_o,
  output logic                     values_agree_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [DivW-1:0]     cfg_data_i
);

  cfg_t cfg_q;
  res_t res_d, res_q;
  logic out_valid_q;
  logic accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period  <= DivW'(2);
      cfg_q.single_ended <= 1'b0;
      cfg_q.odd_select   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HALF_PERIOD:  cfg_q.half_period  <= cfg_data_i;
        CFG_SINGLE_ENDED: cfg_q.single_ended <= cfg_data_i[0];
        CFG_ODD_SELECT:   cfg_q.odd_select   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sar_core u_core (
    .clk_i,
    .rst_ni,
    .adv_i       (accept),
    .start_req_i,
    .data_in_i,
    .cfg_i       (cfg_q),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign select_n_o        = res_q.select_n;
  assign serial_clock_o    = res_q.serial_clock;
  assign data_out_o        = res_q.data_out;
  assign drive_enable_o    = res_q.drive_enable;
  assign busy_res_o        = res_q.busy;
  assign result_valid_o    = res_q.result_valid;
  assign msb_first_value_o = res_q.msb_value;
  assign lsb_first_value_o = res_q.lsb_value;
  assign values_agree_o    = res_q.agree;

endmodule

`default_nettype wire

// ----- hw/rtl/sar_core.sv -----
`default_nettype none

`include "assert_macros.svh"

module sar_core import sar_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire logic start_req_i,
  input  wire logic data_in_i,
  input  wire cfg_t cfg_i,
  output res_t      res_o
);

  phase_e              phase_q, phase_d;
  logic [DivW-1:0]     div_q, div_d;
  logic [BitCntW-1:0]  bit_q, bit_d;
  logic [DataBits-1:0] msb_q, msb_d;
  logic [DataBits-1:0] lsb_q, lsb_d;
  logic                clk_q, clk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      div_q   <= '0;
      bit_q   <= '0;
      msb_q   <= '0;
      lsb_q   <= '0;
      clk_q   <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      div_q   <= div_d;
      bit_q   <= bit_d;
      msb_q   <= msb_d;
      lsb_q   <= lsb_d;
      clk_q   <= clk_d;
    end
  end

  always_comb begin
    logic [DivW-1:0] lim;
    logic            tick;
    logic            busy;
    phase_d = phase_q;
    div_d   = div_q;
    bit_d   = bit_q;
    msb_d   = msb_q;
    lsb_d   = lsb_q;
    clk_d   = clk_q;
    res_o   = '0;
    lim  = (cfg_i.half_period == '0) ? '0 : cfg_i.half_period - DivW'(1);
    tick = (div_q >= lim);
    case (phase_q)
      PH_SETUP, PH_CMD, PH_NULL, PH_MSB, PH_LSB: begin
        div_d = tick ? '0 : div_q + DivW'(1);
        if (tick) begin
          if (phase_q == PH_SETUP) begin
            phase_d = PH_CMD;
            bit_d   = '0;
            clk_d   = 1'b1;
          end else if (phase_q == PH_CMD) begin
            if (clk_q) begin
              clk_d = 1'b0;
              if (bit_q >= BitCntW'(2)) begin
                phase_d = PH_NULL;
                bit_d   = '0;
              end else begin
                bit_d = bit_q + BitCntW'(1);
              end
            end else begin
              clk_d = 1'b1;
            end
          end else if (!clk_q) begin
            if (phase_q == PH_MSB) begin
              msb_d = {msb_q[DataBits-2:0], data_in_i};
            end else if (phase_q == PH_LSB) begin
              lsb_d = {data_in_i, lsb_q[DataBits-1:1]};
            end
            clk_d = 1'b1;
          end else begin
            clk_d = 1'b0;
            if (phase_q == PH_NULL) begin
              phase_d = PH_MSB;
              bit_d   = '0;
            end else if (bit_q >= BitCntW'(DataBits - 1)) begin
              bit_d = '0;
              if (phase_q == PH_MSB) begin
                phase_d = PH_LSB;
              end else begin
                phase_d            = PH_IDLE;
                res_o.result_valid = 1'b1;
              end
            end else begin
              bit_d = bit_q + BitCntW'(1);
            end
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        clk_d   = 1'b0;
        if (start_req_i) begin
          phase_d = PH_SETUP;
          div_d   = '0;
          bit_d   = '0;
          msb_d   = '0;
          lsb_d   = '0;
        end
      end
    endcase

    busy               = (phase_d != PH_IDLE);
    res_o.busy         = busy;
    res_o.select_n     = !busy;
    res_o.serial_clock = clk_d;
    res_o.drive_enable = (phase_d == PH_SETUP) || (phase_d == PH_CMD);
    if (phase_d == PH_SETUP) begin
      res_o.data_out = 1'b1;
    end else if (phase_d == PH_CMD) begin
      if (bit_d == '0) begin
        res_o.data_out = 1'b1;
      end else if (bit_d == BitCntW'(1)) begin
        res_o.data_out = cfg_i.single_ended;
      end else begin
        res_o.data_out = cfg_i.odd_select;
      end
    end
    res_o.msb_value = msb_d;
    res_o.lsb_value = lsb_d;
    res_o.agree     = (msb_d == lsb_d);
  end

  `ASSERT_NEVER(a_bit_range, bit_q > BitCntW'(DataBits - 1), "bit counter out of range")
  `ASSERT_AT(a_idle_clk_low, (phase_q == PH_IDLE) |-> !clk_q, "serial clock high while idle")
  `ASSERT_AT(a_valid_ends, res_o.result_valid |-> (phase_q == PH_LSB && phase_d == PH_IDLE), "result outside end of LSB run")
  `ASSERT_AT(a_cmd_count, (phase_q == PH_CMD) |-> (bit_q <= BitCntW'(2)), "command bit index out of range")

endmodule

`default_nettype wire
